[design/assert_macros.svh]
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEVELS       = 3;
    localparam int UNIT_BYTES   = 32;
    localparam int HEADER_BYTES = 2;

    localparam int NUM_UNITS = 2 ** LEVELS;
    localparam int NUM_NODES = 2 ** (LEVELS + 1) - 1;
    localparam int UNIT_W    = LEVELS;
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int NODE_W    = LEVELS + 1;

    // Port field widths
    localparam int REQ_W     = 16;
    localparam int FUNIT_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int OUNIT_W   = 3;
    localparam int OLEVEL_W  = 2;

    typedef logic [LVL_W-1:0]    t_lvl;
    typedef logic [UNIT_W-1:0]   t_idx;
    typedef logic [NODE_W-1:0]   t_node;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOSPACE = 2'd1;
    localparam t_status ST_BADFREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Tree update commands
    typedef logic [1:0] t_tree_op;
    localparam t_tree_op TREE_NOP   = 2'd0;
    localparam t_tree_op TREE_TAKE  = 2'd1;  // clear node
    localparam t_tree_op TREE_GIVE  = 2'd2;  // set node
    localparam t_tree_op TREE_MERGE = 2'd3;  // clear node and buddy, set parent

    typedef struct packed {
        t_tree_op op;
        t_lvl     lvl;
        t_idx     idx;
    } t_tree_cmd;

    typedef struct packed {
        logic fits;
        t_lvl lvl;
    } t_fit;

    // Flat node index of block idx at level lvl.
    function automatic t_node node_of(input t_lvl lvl, input t_idx idx);
        return (t_node'(1) << lvl) - t_node'(1) + t_node'(idx);
    endfunction

    // Deepest level whose block holds req plus the header.
    function automatic t_fit size_level(input logic [REQ_W-1:0] req);
        t_fit        f;
        logic [31:0] need;
        f    = '0;
        need = 32'(req) + 32'(HEADER_BYTES);
        for (int lv = 0; lv <= LEVELS; lv++) begin
            if (need <= (32'(UNIT_BYTES) << (LEVELS - lv))) begin
                f.fits = 1'b1;
                f.lvl  = t_lvl'(lv);
            end
        end
        return f;
    endfunction

endpackage

[design/bba_if.sv]
// ----------------------------------------------------------------------------
// bba_if
// Request and response channels of the buddy block allocator.
// ----------------------------------------------------------------------------
interface bba_in_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [bba_pkg::REQ_W-1:0]    req_bytes;
    logic [bba_pkg::FUNIT_W-1:0]  free_unit;

    modport source (output valid, output op, output req_bytes, output free_unit,
                    input ready);
    modport sink   (input valid, input op, input req_bytes, input free_unit,
                    output ready);
endinterface

interface bba_out_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::STATUS_W-1:0]  status;
    logic [bba_pkg::OUNIT_W-1:0]   block_unit;
    logic [bba_pkg::OLEVEL_W-1:0]  block_level;

    modport source (output valid, output status, output block_unit,
                    output block_level, input ready);
    modport sink   (input valid, input status, input block_unit,
                    input block_level, output ready);
endinterface

[design/bba_tree.sv]
// ----------------------------------------------------------------------------
// bba_tree
// Free-bit tree: one query level per cycle, one update command per cycle.
// ----------------------------------------------------------------------------
module bba_tree (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bba_pkg::t_tree_cmd i_cmd,
    input  bba_pkg::t_lvl      i_q_lvl,
    input  bba_pkg::t_idx      i_q_idx,
    output logic               o_found,
    output bba_pkg::t_idx      o_low_idx,
    output logic               o_buddy_free
);
    import bba_pkg::*;

    logic [NUM_NODES-1:0] r_free;
    logic [NUM_NODES-1:0] n_free;

    // Lowest free block at the query level
    always_comb begin
        o_found   = 1'b0;
        o_low_idx = '0;
        for (int i = NUM_UNITS - 1; i >= 0; i--) begin
            if ((i < (1 << i_q_lvl)) && r_free[node_of(i_q_lvl, t_idx'(i))]) begin
                o_found   = 1'b1;
                o_low_idx = t_idx'(i);
            end
        end
    end

    assign o_buddy_free = r_free[node_of(i_q_lvl, i_q_idx ^ t_idx'(1))];

    always_comb begin
        n_free = r_free;
        case (i_cmd.op)
            TREE_TAKE: n_free[node_of(i_cmd.lvl, i_cmd.idx)] = 1'b0;
            TREE_GIVE: n_free[node_of(i_cmd.lvl, i_cmd.idx)] = 1'b1;
            TREE_MERGE: begin
                n_free[node_of(i_cmd.lvl, i_cmd.idx)]               = 1'b0;
                n_free[node_of(i_cmd.lvl, i_cmd.idx ^ t_idx'(1))]   = 1'b0;
                n_free[node_of(t_lvl'(i_cmd.lvl - 1'b1), i_cmd.idx >> 1)] = 1'b1;
            end
            default: n_free = r_free;
        endcase
    end

    // only the root node is free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= NUM_NODES'(1);
        end else begin
            r_free <= n_free;
        end
    end

endmodule

[design/buddy_block_allocator.sv]
// Sequence: an oversize request or a bad free is answered from the start state;
//   an allocate searches up from the wanted level and, if it finds a larger
//   block, splits down to it; a free releases the block, then merges upward.
// Throughput: one word at a time; a new word is taken only when idle, and the
//   last step waits while the output register is full and not draining.
// Reset (synchronous, active low): whole region free, no marks, output empty.
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over 2^LEVELS units: allocate by byte size, free by unit.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bba_in_if.sink  i_in,
    bba_out_if.source o_out
);
    import bba_pkg::*;

    `include "assert_macros.svh"

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;  // wait for a request word
    localparam logic [2:0] S_START  = 3'd1;  // size decode / free check
    localparam logic [2:0] S_SEARCH = 3'd2;  // walk up from the wanted level
    localparam logic [2:0] S_SPLIT  = 3'd3;  // split down, right halves freed
    localparam logic [2:0] S_MERGE  = 3'd4;  // merge with free buddy upward

    logic [2:0]       r_state, n_state;
    logic             r_op;
    logic [REQ_W-1:0] r_req;
    logic [FUNIT_W-1:0] r_unit;
    t_lvl             r_want, n_want;
    t_lvl             r_lvl, n_lvl;
    t_idx             r_idx, n_idx;

    // Allocation marks: valid bits reset, levels held without reset
    logic [NUM_UNITS-1:0] r_mark_v;
    t_lvl                 r_mark_lvl [NUM_UNITS];
    logic                 mark_set, mark_clr;
    t_idx                 mark_addr;

    // Output register
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    t_idx    r_out_unit, n_out_unit;
    t_lvl    r_out_level, n_out_level;
    logic    out_free;

    // Shared tree unit
    t_tree_cmd tree_cmd;
    logic      tree_found;
    t_idx      tree_low_idx;
    logic      tree_buddy_free;

    t_fit  fit;
    t_idx  f_addr;
    logic  f_in_range;
    t_lvl  f_lvl;
    t_lvl  sp_lvl;
    t_idx  sp_idx;

    bba_tree u_tree (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (tree_cmd),
        .i_q_lvl      (r_lvl),
        .i_q_idx      (r_idx),
        .o_found      (tree_found),
        .o_low_idx    (tree_low_idx),
        .o_buddy_free (tree_buddy_free)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.block_unit  = OUNIT_W'(r_out_unit);
    assign o_out.block_level = OLEVEL_W'(r_out_level);

    // A result may be loaded when the output register is empty or draining.
    assign out_free = !r_out_valid || o_out.ready;

    assign fit        = size_level(r_req);
    assign f_addr     = t_idx'(r_unit);
    assign f_in_range = (32'(r_unit) < 32'(NUM_UNITS));
    assign f_lvl      = r_mark_lvl[f_addr];
    assign sp_lvl     = t_lvl'(r_lvl + 1'b1);
    assign sp_idx     = t_idx'(r_idx << 1);

    always_comb begin
        n_state      = r_state;
        n_want       = r_want;
        n_lvl        = r_lvl;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_unit   = r_out_unit;
        n_out_level  = r_out_level;
        tree_cmd     = '{op: TREE_NOP, lvl: '0, idx: '0};
        mark_set     = 1'b0;
        mark_clr     = 1'b0;
        mark_addr    = f_addr;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_START;
                end
            end

            S_START: begin
                if (r_op == OP_ALLOC) begin
                    if (fit.fits) begin
                        n_want  = fit.lvl;
                        n_lvl   = fit.lvl;
                        n_state = S_SEARCH;
                    end else if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NOSPACE;
                        n_out_unit   = '0;
                        n_out_level  = '0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    if (f_in_range && r_mark_v[f_addr]) begin
                        // release the block, then try merging upward
                        mark_clr = 1'b1;
                        n_lvl    = f_lvl;
                        n_idx    = t_idx'(f_addr >> (LEVELS - 32'(f_lvl)));
                        tree_cmd = '{op: TREE_GIVE, lvl: n_lvl, idx: n_idx};
                        n_state  = S_MERGE;
                    end else if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_BADFREE;
                        n_out_unit   = '0;
                        n_out_level  = '0;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_SEARCH: begin
                if (tree_found) begin
                    if (r_lvl == r_want) begin
                        if (out_free) begin
                            tree_cmd  = '{op: TREE_TAKE, lvl: r_lvl, idx: tree_low_idx};
                            mark_set  = 1'b1;
                            mark_addr = t_idx'(tree_low_idx << (LEVELS - 32'(r_want)));
                            n_out_valid  = 1'b1;
                            n_out_status = ST_OK;
                            n_out_unit   = mark_addr;
                            n_out_level  = r_want;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        tree_cmd = '{op: TREE_TAKE, lvl: r_lvl, idx: tree_low_idx};
                        n_idx    = tree_low_idx;
                        n_state  = S_SPLIT;
                    end
                end else if (r_lvl == '0) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NOSPACE;
                        n_out_unit   = '0;
                        n_out_level  = '0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_lvl = t_lvl'(r_lvl - 1'b1);
                end
            end

            S_SPLIT: begin
                // keep left half, free right half
                if (sp_lvl != r_want || out_free) begin
                    tree_cmd = '{op: TREE_GIVE, lvl: sp_lvl, idx: sp_idx | t_idx'(1)};
                    n_lvl    = sp_lvl;
                    n_idx    = sp_idx;
                    if (sp_lvl == r_want) begin
                        mark_set     = 1'b1;
                        mark_addr    = t_idx'(sp_idx << (LEVELS - 32'(sp_lvl)));
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_out_unit   = mark_addr;
                        n_out_level  = sp_lvl;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_MERGE: begin
                if (r_lvl != '0 && tree_buddy_free) begin
                    tree_cmd = '{op: TREE_MERGE, lvl: r_lvl, idx: r_idx};
                    n_lvl    = t_lvl'(r_lvl - 1'b1);
                    n_idx    = r_idx >> 1;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_unit   = t_idx'(r_idx << (LEVELS - 32'(r_lvl)));
                    n_out_level  = r_lvl;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mark_v    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (mark_set) begin
                r_mark_v[mark_addr] <= 1'b1;
            end else if (mark_clr) begin
                r_mark_v[mark_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op   <= i_in.op;
            r_req  <= i_in.req_bytes;
            r_unit <= i_in.free_unit;
        end
        r_want       <= n_want;
        r_lvl        <= n_lvl;
        r_idx        <= n_idx;
        r_out_status <= n_out_status;
        r_out_unit   <= n_out_unit;
        r_out_level  <= n_out_level;
        if (mark_set) begin
            r_mark_lvl[mark_addr] <= r_want;
        end
    end

    // ---- assertions ----
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n,
        i_in.valid && i_in.ready, r_state == S_START,
        "accepted word did not start the sequencer")
    `ASSERT_SAME(a_split_above_want, i_clk, i_rst_n,
        r_state == S_SPLIT, r_lvl < r_want,
        "split level reached past the wanted level")
    `ASSERT_SAME(a_status_legal, i_clk, i_rst_n,
        r_out_valid,
        r_out_status == ST_OK || r_out_status == ST_NOSPACE || r_out_status == ST_BADFREE,
        "illegal status code in output register")
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_out_unit) && $stable(r_out_level),
        "pending result lost or changed")

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking regression for the buddy block allocator
// Sends a short directed run and then about 1800 random allocate and free
// words. Random frees mostly target blocks that are live. The checker keeps
// its own copy of the buddy tree and the allocation marks, and compares every
// response word with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 12;    // margin after the last response
    localparam int TREE_SLOTS   = 2 ** (LEVELS + 1);

    // Request word as the driver sends it.
    typedef struct packed {
        logic                op;
        logic [REQ_W-1:0]    req_bytes;
        logic [FUNIT_W-1:0]  free_unit;
    } t_req_word;

    // Response word the allocator is expected to return.
    typedef struct packed {
        t_status             status;
        logic [OUNIT_W-1:0]  unit;
        logic [OLEVEL_W-1:0] lvl;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bba_in_if  req_ch ();
    bba_out_if rsp_ch ();

    buddy_block_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow allocator state.
    // Tree slots are numbered level by level: slot (2^lvl - 1 + idx) is the
    // block idx at level lvl. Level 0 is the whole region.
    // ------------------------------------------------------------------------
    logic tree_free [TREE_SLOTS];
    logic mark_live [NUM_UNITS];
    t_lvl mark_lvl  [NUM_UNITS];

    t_req_word word_q[$];    // words waiting for the driver
    t_grant    grant_q[$];   // predicted responses, oldest first
    t_req_word cur_word;     // word currently offered on the request channel

    int  n_errors     = 0;
    int  n_sent       = 0;
    int  n_alloc_ok   = 0;
    int  n_nospace    = 0;
    int  n_free_ok    = 0;
    int  n_badfree    = 0;
    int  n_root_merge = 0;
    int  send_gap     = 0;
    int  sink_hold    = 0;
    int  idle_cycles  = 0;
    bit  calm         = 1'b0;  // when set, neither side inserts idle cycles

    // Allocate: deepest level whose block holds the payload plus header, the
    // lowest free block there, else split down the lowest free block from the
    // nearest shallower level. Right halves produced by the split become free.
    function automatic t_grant take_block(input logic [REQ_W-1:0] req);
        t_grant g;
        int     need;
        int     want;
        int     l;
        int     idx;
        bit     found;
        g     = '{status: ST_NOSPACE, unit: '0, lvl: '0};
        need  = int'(req) + HEADER_BYTES;
        want  = -1;
        found = 1'b0;
        for (int lv = 0; lv <= LEVELS; lv++) begin
            if (need <= (UNIT_BYTES << (LEVELS - lv)))
                want = lv;
        end
        if (want < 0)
            return g;
        for (int lv = want; lv >= 0 && !found; lv--) begin
            for (int i = 0; i < (1 << lv) && !found; i++) begin
                if (tree_free[(1 << lv) - 1 + i]) begin
                    found = 1'b1;
                    tree_free[(1 << lv) - 1 + i] = 1'b0;
                    l   = lv;
                    idx = i;
                    while (l < want) begin
                        l++;
                        idx = idx * 2;
                        tree_free[(1 << l) - 1 + idx + 1] = 1'b1;
                    end
                    idx = idx << (LEVELS - want);
                    mark_live[idx] = 1'b1;
                    mark_lvl[idx]  = t_lvl'(want);
                    g = '{status: ST_OK, unit: OUNIT_W'(idx), lvl: OLEVEL_W'(want)};
                end
            end
        end
        return g;
    endfunction

    // Free: release the block that starts at unit and merge upward while the
    // buddy is free. Reports the start and level of the merged block.
    function automatic t_grant release_block(input logic [FUNIT_W-1:0] unit);
        int l;
        int idx;
        if (!mark_live[unit])
            return '{status: ST_BADFREE, unit: '0, lvl: '0};
        l   = int'(mark_lvl[unit]);
        idx = int'(unit) >> (LEVELS - l);
        mark_live[unit] = 1'b0;
        mark_lvl[unit]  = '0;
        tree_free[(1 << l) - 1 + idx] = 1'b1;
        while (l > 0 && tree_free[(1 << l) - 1 + (idx ^ 1)]) begin
            tree_free[(1 << l) - 1 + idx]       = 1'b0;
            tree_free[(1 << l) - 1 + (idx ^ 1)] = 1'b0;
            l--;
            idx = idx >> 1;
            tree_free[(1 << l) - 1 + idx] = 1'b1;
        end
        return '{status: ST_OK, unit: OUNIT_W'(idx << (LEVELS - l)), lvl: OLEVEL_W'(l)};
    endfunction

    // Idle length: mostly none, sometimes a few cycles, rarely a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 24);
    endfunction

    function automatic t_req_word mk_word(input logic op, input int req, input int unit);
        return '{op: op, req_bytes: REQ_W'(req), free_unit: FUNIT_W'(unit)};
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A word is predicted at the edge where it is accepted,
    // which is also the order in which the allocator serves it. The shadow
    // state resets along with the allocator.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.op        <= OP_ALLOC;
            req_ch.req_bytes <= '0;
            req_ch.free_unit <= '0;
            send_gap         = 0;
            for (int s = 0; s < TREE_SLOTS; s++)
                tree_free[s] = (s == 0);
            for (int u = 0; u < NUM_UNITS; u++) begin
                mark_live[u] = 1'b0;
                mark_lvl[u]  = '0;
            end
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                if (cur_word.op == OP_ALLOC)
                    grant_q.push_back(take_block(cur_word.req_bytes));
                else
                    grant_q.push_back(release_block(cur_word.free_unit));
                case ({cur_word.op, grant_q[$].status})
                    {OP_ALLOC, ST_OK}:      n_alloc_ok++;
                    {OP_ALLOC, ST_NOSPACE}: n_nospace++;
                    {OP_FREE,  ST_OK}: begin
                        n_free_ok++;
                        if (grant_q[$].lvl == '0)
                            n_root_merge++;
                    end
                    default:                n_badfree++;
                endcase
                n_sent++;
                send_gap = calm ? 0 : pick_gap();
            end
            // Only move on once the offered word is gone (or none is offered).
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    cur_word            = word_q.pop_front();
                    req_ch.op           <= cur_word.op;
                    req_ch.req_bytes    <= cur_word.req_bytes;
                    req_ch.free_unit    <= cur_word.free_unit;
                    req_ch.valid        <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor with random back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            sink_hold    = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (grant_q.size() == 0) begin
                    note_error($sformatf("response with none pending: status %0d unit %0d level %0d",
                                         rsp_ch.status, rsp_ch.block_unit, rsp_ch.block_level));
                end else begin
                    want = grant_q.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.block_unit !== want.unit ||
                        rsp_ch.block_level !== want.lvl)
                        note_error($sformatf(
                            "status exp %0d got %0d, unit exp %0d got %0d, level exp %0d got %0d",
                            want.status, rsp_ch.status, want.unit, rsp_ch.block_unit,
                            want.lvl, rsp_ch.block_level));
                end
            end
            if (sink_hold > 0) begin
                sink_hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    sink_hold = pick_gap();
            end
        end
    end

    // Watchdog: a stuck handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles, %0d responses outstanding",
                         $realtime, IDLE_LIMIT, grant_q.size());
                $display("buddy_block_allocator regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int live[$];
        int r;
        int req;

        i_rst_n = 1'b0;

        // Directed words: size boundaries of every level, region full,
        // oversize and all-ones requests, bad frees, and a free of every unit
        // so merges go all the way back to the root.
        word_q.push_back(mk_word(OP_FREE,  16'hffff, 0));   // nothing live yet
        word_q.push_back(mk_word(OP_ALLOC, 254, 7));        // exactly the region
        word_q.push_back(mk_word(OP_ALLOC, 0, 0));          // region taken
        word_q.push_back(mk_word(OP_FREE,  0, 0));
        word_q.push_back(mk_word(OP_ALLOC, 255, 0));        // one byte too many
        word_q.push_back(mk_word(OP_ALLOC, 65535, 7));
        word_q.push_back(mk_word(OP_ALLOC, 0, 0));          // header only: one unit
        word_q.push_back(mk_word(OP_ALLOC, 30, 0));         // fills one unit
        word_q.push_back(mk_word(OP_ALLOC, 31, 0));         // spills to two units
        word_q.push_back(mk_word(OP_ALLOC, 62, 0));
        word_q.push_back(mk_word(OP_ALLOC, 63, 0));
        word_q.push_back(mk_word(OP_ALLOC, 126, 0));
        word_q.push_back(mk_word(OP_ALLOC, 127, 0));
        for (int u = 0; u < NUM_UNITS; u++)
            word_q.push_back(mk_word(OP_FREE, 0, u));
        word_q.push_back(mk_word(OP_ALLOC, 1, 5));
        word_q.push_back(mk_word(OP_FREE,  0, 7));
        word_q.push_back(mk_word(OP_ALLOC, 32767, 2));
        word_q.push_back(mk_word(OP_FREE,  0, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random part. Each word is chosen once the previous one has been
        // taken, so frees can aim at blocks that are live (give or take the
        // word still on the channel).
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            do
                @(negedge i_clk);
            while (word_q.size() != 0);
            if (n % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            live.delete();
            for (int u = 0; u < NUM_UNITS; u++)
                if (mark_live[u])
                    live.push_back(u);
            if (live.size() == 0 || $urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    req = $urandom_range(0, 30);
                else if (r < 60)
                    req = $urandom_range(31, 62);
                else if (r < 75)
                    req = $urandom_range(63, 126);
                else if (r < 85)
                    req = $urandom_range(127, 254);
                else if (r < 93)
                    req = $urandom_range(255, 65535);
                else
                    req = $urandom() & 16'hffff;
                word_q.push_back(mk_word(OP_ALLOC, req, $urandom_range(0, 7)));
            end else if ($urandom_range(0, 99) < 85) begin
                word_q.push_back(mk_word(OP_FREE, $urandom() & 16'hffff,
                                         live[$urandom_range(0, live.size() - 1)]));
            end else begin
                word_q.push_back(mk_word(OP_FREE, $urandom() & 16'hffff, $urandom_range(0, 7)));
            end
        end

        // Drain: everything sent, every response back, then a latency margin.
        while (word_q.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        while (grant_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d allocations granted, %0d refused for lack of space.",
                 n_sent, n_alloc_ok, n_nospace);
        $display("Frees: %0d released (%0d merged up to the whole region), %0d rejected.",
                 n_free_ok, n_root_merge, n_badfree);
        if (n_errors == 0 && grant_q.size() == 0) begin
            $display("buddy_block_allocator regression: pass");
        end else begin
            $display("%0d errors", n_errors);
            $display("buddy_block_allocator regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/bba_pkg.sv
design/bba_if.sv
design/bba_tree.sv
design/buddy_block_allocator.sv
bench/tb_top.sv
